// ===== rtl/usbmsc_pkg.sv =====
// ----------------------------------------------------------------------------
// usbmsc_pkg
// Shared constants and types for the USB mass-storage descriptor scanner.
// ----------------------------------------------------------------------------
package usbmsc_pkg;

  localparam logic [7:0] TypeInterface = 8'h04;
  localparam logic [7:0] TypeEndpoint  = 8'h05;
  localparam logic [1:0] AttrXferMask  = 2'h3;
  localparam logic [1:0] AttrBulk      = 2'h2;
  localparam int unsigned AddrDirBit   = 7;

  localparam logic [7:0] ClassReset    = 8'h08;
  localparam logic [7:0] SubclassReset = 8'h06;
  localparam logic [7:0] ProtocolReset = 8'h50;

  localparam logic [1:0] CfgClass    = 2'd0;
  localparam logic [1:0] CfgSubclass = 2'd1;
  localparam logic [1:0] CfgProtocol = 2'd2;

  localparam logic StatusOk          = 1'b0;
  localparam logic StatusUnsupported = 1'b1;

  typedef struct packed {
    logic       status_code;
    logic       interface_found;
    logic       in_found;
    logic       out_found;
    logic [3:0] in_endpoint;
    logic [3:0] out_endpoint;
    logic [7:0] interface_number;
  } scan_res_t;

endpackage

// ===== rtl/usb_msc_descriptor_scanner_core.sv =====
// ----------------------------------------------------------------------------
// usb_msc_descriptor_scanner_core
// Walks a USB configuration descriptor set byte by byte and reports the
// matching storage interface and its bulk endpoints on the last byte.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  in      | in_valid_i/in_stall_o | data_byte_i, last_byte_i
//  out     | out_valid_o/out_stall_i | status, flags, endpoints, interface
//  cfg     | cfg_we_i             | cfg_index_i, cfg_data_i
//
//  One request per cycle while in_stall_o is low. A byte goes through an input
//  register, then the scan logic updates state and loads the result register.
//  A waiting result that is stalled holds both stages; in_stall_o follows a
//  full input register that cannot advance. Reset clears the scan state and
//  loads the default class 08h, subclass 06h, protocol 50h.
// ----------------------------------------------------------------------------
module usb_msc_descriptor_scanner_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] data_byte_i,
  input  logic       last_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       status_code_o,
  output logic       interface_found_o,
  output logic       in_found_o,
  output logic       out_found_o,
  output logic [3:0] in_endpoint_o,
  output logic [3:0] out_endpoint_o,
  output logic [7:0] interface_number_o,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_index_i,
  input  logic [7:0] cfg_data_i
);
  import usbmsc_pkg::*;

  logic [7:0] class_q, subclass_q, protocol_q;
  logic       ivalid_q;
  logic [7:0] ibyte_q;
  logic       ilast_q;
  logic       ovalid_q;
  scan_res_t  ores_q;
  scan_res_t  res;
  logic       advance;
  logic       step;

  assign advance    = !(ovalid_q && out_stall_i);
  assign step       = ivalid_q && advance;
  assign in_stall_o = ivalid_q && !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      class_q    <= ClassReset;
      subclass_q <= SubclassReset;
      protocol_q <= ProtocolReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgClass:    class_q    <= cfg_data_i;
        CfgSubclass: subclass_q <= cfg_data_i;
        CfgProtocol: protocol_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ivalid_q <= 1'b0;
    end else if (!in_stall_o) begin
      ivalid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      ibyte_q <= data_byte_i;
      ilast_q <= last_byte_i;
    end
  end

  usbmsc_scan u_scan (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .step_i          (step),
    .data_byte_i     (ibyte_q),
    .last_byte_i     (ilast_q),
    .class_code_i    (class_q),
    .subclass_code_i (subclass_q),
    .protocol_code_i (protocol_q),
    .res_o           (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if (advance) begin
      ovalid_q <= step && ilast_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && ilast_q) begin
      ores_q <= res;
    end
  end

  assign out_valid_o        = ovalid_q;
  assign status_code_o      = ores_q.status_code;
  assign interface_found_o  = ores_q.interface_found;
  assign in_found_o         = ores_q.in_found;
  assign out_found_o        = ores_q.out_found;
  assign in_endpoint_o      = ores_q.in_endpoint;
  assign out_endpoint_o     = ores_q.out_endpoint;
  assign interface_number_o = ores_q.interface_number;

endmodule

// ===== rtl/usbmsc_scan.sv =====
// ----------------------------------------------------------------------------
// usbmsc_scan
// Descriptor chain walker: per-byte scan state and the summary of one set.
// ----------------------------------------------------------------------------
module usbmsc_scan (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_i,
  input  logic [7:0]            data_byte_i,
  input  logic                  last_byte_i,
  input  logic [7:0]            class_code_i,
  input  logic [7:0]            subclass_code_i,
  input  logic [7:0]            protocol_code_i,
  output usbmsc_pkg::scan_res_t res_o
);
  import usbmsc_pkg::*;

  logic [7:0] offset_q, offset_d;
  logic [7:0] length_q, length_d;
  logic [7:0] type_q, type_d;
  logic [7:0] hclass_q, hclass_d;
  logic [7:0] hsub_q, hsub_d;
  logic [7:0] hifnum_q, hifnum_d;
  logic [7:0] hepaddr_q, hepaddr_d;
  logic       match_q, match_d;
  logic       in_q, in_d;
  logic       out_q, out_d;
  logic [3:0] in_ep_q, in_ep_d;
  logic [3:0] out_ep_q, out_ep_d;
  logic [7:0] ifnum_q, ifnum_d;
  logic       stopped_q, stopped_d;
  logic [8:0] off_inc;
  logic [7:0] len_eff;

  always_comb begin
    offset_d  = offset_q;
    length_d  = length_q;
    type_d    = type_q;
    hclass_d  = hclass_q;
    hsub_d    = hsub_q;
    hifnum_d  = hifnum_q;
    hepaddr_d = hepaddr_q;
    match_d   = match_q;
    in_d      = in_q;
    out_d     = out_q;
    in_ep_d   = in_ep_q;
    out_ep_d  = out_ep_q;
    ifnum_d   = ifnum_q;
    stopped_d = stopped_q;
    off_inc   = {1'b0, offset_q} + 9'd1;
    len_eff   = (offset_q == 8'd0) ? data_byte_i : length_q;

    if (!stopped_q) begin
      if (offset_q == 8'd0 && data_byte_i == 8'd0) begin
        stopped_d = 1'b1;
      end else begin
        if (offset_q == 8'd0) begin
          length_d = data_byte_i;
          type_d   = 8'd0;
        end else if (offset_q == 8'd1) begin
          type_d = data_byte_i;
        end else if (type_q == TypeInterface) begin
          if (offset_q == 8'd2) begin
            hifnum_d = data_byte_i;
          end else if (offset_q == 8'd5) begin
            hclass_d = data_byte_i;
          end else if (offset_q == 8'd6) begin
            hsub_d = data_byte_i;
          end else if (offset_q == 8'd7) begin
            if (hclass_q == class_code_i && hsub_q == subclass_code_i &&
                data_byte_i == protocol_code_i) begin
              match_d = 1'b1;
              ifnum_d = hifnum_q;
            end
          end
        end else if (type_q == TypeEndpoint) begin
          if (offset_q == 8'd2) begin
            hepaddr_d = data_byte_i;
          end else if (offset_q == 8'd3 && match_q &&
                       (data_byte_i[1:0] & AttrXferMask) == AttrBulk) begin
            if (hepaddr_q[AddrDirBit]) begin
              in_ep_d = hepaddr_q[3:0];
              in_d    = 1'b1;
            end else begin
              out_ep_d = hepaddr_q[3:0];
              out_d    = 1'b1;
            end
          end
        end
        offset_d = (off_inc >= {1'b0, len_eff}) ? 8'd0 : off_inc[7:0];
      end
    end
  end

  always_comb begin
    res_o.status_code      = (match_d && in_d && out_d) ? StatusOk : StatusUnsupported;
    res_o.interface_found  = match_d;
    res_o.in_found         = in_d;
    res_o.out_found        = out_d;
    res_o.in_endpoint      = in_ep_d;
    res_o.out_endpoint     = out_ep_d;
    res_o.interface_number = ifnum_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q  <= '0;
      length_q  <= '0;
      type_q    <= '0;
      hclass_q  <= '0;
      hsub_q    <= '0;
      hifnum_q  <= '0;
      hepaddr_q <= '0;
      match_q   <= 1'b0;
      in_q      <= 1'b0;
      out_q     <= 1'b0;
      in_ep_q   <= '0;
      out_ep_q  <= '0;
      ifnum_q   <= '0;
      stopped_q <= 1'b0;
    end else if (step_i) begin
      if (last_byte_i) begin
        offset_q  <= '0;
        length_q  <= '0;
        type_q    <= '0;
        hclass_q  <= '0;
        hsub_q    <= '0;
        hifnum_q  <= '0;
        hepaddr_q <= '0;
        match_q   <= 1'b0;
        in_q      <= 1'b0;
        out_q     <= 1'b0;
        in_ep_q   <= '0;
        out_ep_q  <= '0;
        ifnum_q   <= '0;
        stopped_q <= 1'b0;
      end else begin
        offset_q  <= offset_d;
        length_q  <= length_d;
        type_q    <= type_d;
        hclass_q  <= hclass_d;
        hsub_q    <= hsub_d;
        hifnum_q  <= hifnum_d;
        hepaddr_q <= hepaddr_d;
        match_q   <= match_d;
        in_q      <= in_d;
        out_q     <= out_d;
        in_ep_q   <= in_ep_d;
        out_ep_q  <= out_ep_d;
        ifnum_q   <= ifnum_d;
        stopped_q <= stopped_d;
      end
    end
  end

endmodule

// ===== tb/usb_msc_descriptor_scanner_core_tb.sv =====
// ----------------------------------------------------------------------------
// usb_msc_descriptor_scanner_core_tb
// Feeds descriptor sets byte by byte into the scanner, predicts the scan
// result of every set and checks each result against the oldest prediction,
// across several class/subclass/protocol settings and idle/stall mixes.
// ----------------------------------------------------------------------------
import usbmsc_pkg::*;

class scan_scoreboard;
  logic [7:0] class_code;
  logic [7:0] subclass_code;
  logic [7:0] protocol_code;
  logic [7:0] offset;
  logic [7:0] desc_len;
  logic [7:0] desc_type;
  logic [7:0] held_class;
  logic [7:0] held_subclass;
  logic [7:0] held_ifnum;
  logic [7:0] held_epaddr;
  logic       matched;
  logic       in_seen;
  logic       out_seen;
  logic       halted;
  logic [3:0] in_ep;
  logic [3:0] out_ep;
  logic [7:0] ifnum;
  scan_res_t  expected_q[$];
  int         mismatches;
  int         results;

  function new();
    class_code    = ClassReset;
    subclass_code = SubclassReset;
    protocol_code = ProtocolReset;
    mismatches    = 0;
    results       = 0;
    clear_scan();
  endfunction

  function void clear_scan();
    offset        = '0;
    desc_len      = '0;
    desc_type     = '0;
    held_class    = '0;
    held_subclass = '0;
    held_ifnum    = '0;
    held_epaddr   = '0;
    matched       = 1'b0;
    in_seen       = 1'b0;
    out_seen      = 1'b0;
    halted        = 1'b0;
    in_ep         = '0;
    out_ep        = '0;
    ifnum         = '0;
  endfunction

  function void set_code(logic [1:0] idx, logic [7:0] val);
    case (idx)
      CfgClass:    class_code = val;
      CfgSubclass: subclass_code = val;
      CfgProtocol: protocol_code = val;
      default: ;
    endcase
  endfunction

  function void scan_byte(logic [7:0] b);
    if (halted) return;
    if (offset == 8'd0) begin
      if (b == 8'd0) begin
        halted = 1'b1;
        return;
      end
      desc_len  = b;
      desc_type = '0;
    end else if (offset == 8'd1) begin
      desc_type = b;
    end else if (desc_type == TypeInterface) begin
      case (offset)
        8'd2: held_ifnum = b;
        8'd5: held_class = b;
        8'd6: held_subclass = b;
        8'd7: begin
          if (held_class == class_code && held_subclass == subclass_code &&
              b == protocol_code) begin
            matched = 1'b1;
            ifnum   = held_ifnum;
          end
        end
        default: ;
      endcase
    end else if (desc_type == TypeEndpoint) begin
      if (offset == 8'd2) begin
        held_epaddr = b;
      end else if (offset == 8'd3 && matched && (b[1:0] & AttrXferMask) == AttrBulk) begin
        if (held_epaddr[AddrDirBit]) begin
          in_ep   = held_epaddr[3:0];
          in_seen = 1'b1;
        end else begin
          out_ep   = held_epaddr[3:0];
          out_seen = 1'b1;
        end
      end
    end
    if (int'(offset) + 1 >= int'(desc_len)) offset = '0;
    else offset = offset + 8'd1;
  endfunction

  function void note_request(logic [7:0] b, logic last);
    scan_res_t r;
    scan_byte(b);
    if (last) begin
      r.status_code      = (matched && in_seen && out_seen) ? StatusOk : StatusUnsupported;
      r.interface_found  = matched;
      r.in_found         = in_seen;
      r.out_found        = out_seen;
      r.in_endpoint      = in_ep;
      r.out_endpoint     = out_ep;
      r.interface_number = ifnum;
      expected_q.push_back(r);
      clear_scan();
    end
  endfunction

  function void check_result(scan_res_t got);
    scan_res_t want;
    if (expected_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected result: st=%0d if=%0d in=%0d out=%0d inep=%0d outep=%0d ifn=%0d",
                 got.status_code, got.interface_found, got.in_found, got.out_found,
                 got.in_endpoint, got.out_endpoint, got.interface_number);
      return;
    end
    want = expected_q.pop_front();
    results++;
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("result %0d expected: st=%0d if=%0d in=%0d out=%0d inep=%0d outep=%0d ifn=%0d",
                 results, want.status_code, want.interface_found, want.in_found,
                 want.out_found, want.in_endpoint, want.out_endpoint,
                 want.interface_number);
        $display("result %0d actual:   st=%0d if=%0d in=%0d out=%0d inep=%0d outep=%0d ifn=%0d",
                 results, got.status_code, got.interface_found, got.in_found,
                 got.out_found, got.in_endpoint, got.out_endpoint,
                 got.interface_number);
      end
    end
  endfunction

  function int pending();
    return expected_q.size();
  endfunction
endclass

module usb_msc_descriptor_scanner_core_tb;
  localparam logic [7:0] TypeConfig = 8'h02;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] data_byte;
  logic       last_byte;
  logic       out_valid;
  logic       out_stall;
  logic       status_code;
  logic       interface_found;
  logic       in_found;
  logic       out_found;
  logic [3:0] in_endpoint;
  logic [3:0] out_endpoint;
  logic [7:0] interface_number;
  logic       cfg_we;
  logic [1:0] cfg_index;
  logic [7:0] cfg_data;

  int         snd_idle;
  int         rcv_stall;
  int         hold_left;
  logic [7:0] set_q[$];
  logic [7:0] desc_q[$];
  scan_res_t  dut_res;

  scan_scoreboard sb = new();

  usb_msc_descriptor_scanner_core dut (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall),
    .data_byte_i       (data_byte),
    .last_byte_i       (last_byte),
    .out_valid_o       (out_valid),
    .out_stall_i       (out_stall),
    .status_code_o     (status_code),
    .interface_found_o (interface_found),
    .in_found_o        (in_found),
    .out_found_o       (out_found),
    .in_endpoint_o     (in_endpoint),
    .out_endpoint_o    (out_endpoint),
    .interface_number_o(interface_number),
    .cfg_we_i          (cfg_we),
    .cfg_index_i       (cfg_index),
    .cfg_data_i        (cfg_data)
  );

  assign dut_res = {status_code, interface_found, in_found, out_found,
                    in_endpoint, out_endpoint, interface_number};

  always #10 clk = ~clk;

  // receiver: long hold-off when requested, random stall otherwise
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < rcv_stall);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(dut_res);
  end

  initial begin
    #2000000;
    $display("end of test: mismatches");
    $finish;
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(0, 99) < snd_idle) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid  <= 1'b1;
    data_byte <= b;
    last_byte <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(b, last);
  endtask

  task automatic send_set();
    int i;
    for (i = 0; i < set_q.size(); i++) send_byte(set_q[i], i == set_q.size() - 1);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [7:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.set_code(idx, val);
  endtask

  // append the first len bytes of desc_q, padding with random bytes
  task automatic push_desc(input int len);
    int k;
    for (k = 0; k < len; k++)
      set_q.push_back(k < desc_q.size() ? desc_q[k] : 8'($urandom_range(0, 255)));
    desc_q.delete();
  endtask

  task automatic make_set();
    int n;
    int kind;
    int len;
    int r;
    int k;
    set_q.delete();
    desc_q.delete();
    if ($urandom_range(0, 9) == 0) begin
      n = $urandom_range(1, 8);
      for (k = 0; k < n; k++) set_q.push_back(8'($urandom_range(0, 255)));
      return;
    end
    if ($urandom_range(0, 2) == 0) begin
      desc_q.push_back(8'd9);
      desc_q.push_back(TypeConfig);
      push_desc(9);
    end
    n = $urandom_range(1, 3);
    for (k = 0; k < n; k++) begin
      kind = $urandom_range(0, 9);
      if (kind < 4) begin
        r = $urandom_range(0, 9);
        len = (r < 6) ? 9 : (r == 6) ? 7 : (r == 7) ? 8 : $urandom_range(10, 12);
        desc_q.push_back(8'(len));
        desc_q.push_back(TypeInterface);
        desc_q.push_back(8'($urandom_range(0, 255)));
        desc_q.push_back(8'($urandom_range(0, 255)));
        desc_q.push_back(8'($urandom_range(0, 255)));
        desc_q.push_back(($urandom_range(0, 4) != 0) ? sb.class_code
                                                      : 8'($urandom_range(0, 255)));
        desc_q.push_back(($urandom_range(0, 4) != 0) ? sb.subclass_code
                                                      : 8'($urandom_range(0, 255)));
        desc_q.push_back(($urandom_range(0, 4) != 0) ? sb.protocol_code
                                                      : 8'($urandom_range(0, 255)));
        push_desc(len);
      end else if (kind < 8) begin
        len = ($urandom_range(0, 9) < 7) ? 7 : $urandom_range(3, 6);
        desc_q.push_back(8'(len));
        desc_q.push_back(TypeEndpoint);
        desc_q.push_back(8'($urandom_range(0, 255)));
        desc_q.push_back(($urandom_range(0, 3) != 0) ? {6'($urandom_range(0, 63)), AttrBulk}
                                                      : 8'($urandom_range(0, 255)));
        push_desc(len);
      end else if (kind == 8) begin
        len = $urandom_range(1, 4);
        desc_q.push_back(8'(len));
        push_desc(len);
      end else begin
        set_q.push_back(8'd0);
        push_desc($urandom_range(0, 3));
      end
    end
    // set cut short inside a descriptor
    if ($urandom_range(0, 4) == 0 && set_q.size() > 1) begin
      r = $urandom_range(1, set_q.size() - 1);
      for (k = 0; k < r; k++) void'(set_q.pop_back());
    end
  endtask

  initial begin
    int p;
    int sets;
    int items;
    clk       = 1'b0;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    data_byte = '0;
    last_byte = 1'b0;
    out_stall = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    snd_idle  = 0;
    rcv_stall = 0;
    hold_left = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // minimal matching interface, bulk IN and OUT, reset codes
    set_q = '{8'h08, TypeInterface, 8'hFF, 8'h00, 8'h02, 8'h08, 8'h06, 8'h50,
              8'h04, TypeEndpoint, 8'h8F, 8'h02,
              8'h04, TypeEndpoint, 8'h00, 8'hFE};
    send_set();
    // zero length as the only byte
    set_q = '{8'h00};
    send_set();
    // length one without type, then zero length stops the scan
    set_q = '{8'h01, 8'h00, 8'hFF};
    send_set();
    // endpoint too short to record, set ends with it
    set_q = '{8'h03, TypeEndpoint, 8'h81};
    send_set();

    for (p = 0; p < 4; p++) begin
      wait_drained();
      case (p)
        0: begin
          cfg_write(CfgClass, 8'hFF);
          cfg_write(CfgSubclass, 8'hFF);
          cfg_write(CfgProtocol, 8'hFF);
        end
        1: begin
          cfg_write(CfgClass, 8'h00);
          cfg_write(CfgSubclass, 8'h00);
          cfg_write(CfgProtocol, 8'h00);
        end
        2: begin
          cfg_write(CfgClass, ClassReset);
          cfg_write(CfgSubclass, SubclassReset);
          cfg_write(CfgProtocol, ProtocolReset);
        end
        default: begin
          cfg_write(CfgClass, 8'($urandom_range(0, 255)));
          cfg_write(CfgSubclass, 8'($urandom_range(0, 255)));
          cfg_write(CfgProtocol, 8'($urandom_range(0, 255)));
        end
      endcase
      snd_idle  = (p == 1) ? 68 : (p == 3) ? 32 : 0;
      rcv_stall = (p == 2) ? 68 : (p == 3) ? 32 : 0;
      if (p == 0) hold_left = 80;
      sets  = 0;
      items = 0;
      while (items < 100 || sets < 9) begin
        make_set();
        items += set_q.size();
        sets++;
        send_set();
        // sender waits for all requests to finish once mid-phase
        if (p == 2 && sets == 4) wait_drained();
      end
    end

    wait_drained();
    repeat (10) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
rtl/usbmsc_pkg.sv
rtl/usbmsc_scan.sv
rtl/usb_msc_descriptor_scanner_core.sv
tb/usb_msc_descriptor_scanner_core_tb.sv
